>>> sv/assert_macros.svh
// Assertion macros for the top level of the integer matrix multiplier.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when pre holds, post must hold too.
`define IMM_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication: when pre holds, post must hold in the next cycle.
`define IMM_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> sv/imm_pkg.sv
// Shared types and constants of the integer matrix multiplier.
// No dependencies; the MAC, the sequencer and the top level import this package.
package imm_pkg;

	// Matrix element width and configuration port geometry.
	localparam int WORD_W    = 32;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 2;

	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [CFG_W-1:0]     cfg_data_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t REG_ROWS_A    = 2'd0;
	localparam cfg_idx_t REG_ROWS_B    = 2'd1;
	localparam cfg_idx_t REG_INNER_LEN = 2'd2;

	// Sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} imm_state_t;

endpackage

>>> sv/imm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing but its parameters.
module imm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/imm_mac.sv
// Shared multiply-accumulate unit: one product and one addition per cycle.
// Depends on imm_pkg for the word type.
module imm_mac (
	input  logic          clk,
	input  imm_pkg::word_t a_elem,
	input  imm_pkg::word_t b_elem,
	input  imm_pkg::word_t sum_in,
	input  logic          clear_sum,
	output imm_pkg::word_t total
);
	import imm_pkg::*;

	word_t prod;
	word_t prod_s2;
	word_t addend_s2;

	// The product wraps to the word width.
	assign prod = a_elem * b_elem;

	// Register the product; the first inner step starts from zero.
	always_ff @(posedge clk) begin
		prod_s2   <= prod;
		addend_s2 <= clear_sum ? '0 : sum_in;
	end

	assign total = prod_s2 + addend_s2;

endmodule

>>> sv/imm_ctrl.sv
// Sequencer of the matrix multiplier: configuration, stream counters,
// memory addressing and result registers. Depends on imm_pkg.
module imm_ctrl #(
	parameter int MAX_DIM = 32,
	localparam int IDX_W = $clog2(MAX_DIM),
	localparam int DIM_W = $clog2(MAX_DIM + 1),
	localparam int AADR_W = 2 * IDX_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  imm_pkg::cfg_idx_t  cfg_index,
	input  imm_pkg::cfg_data_t cfg_data,
	input  logic               start,
	input  imm_pkg::word_t     word,
	output logic               busy,
	output logic               a_we,
	output logic [AADR_W-1:0]  a_waddr,
	output logic [AADR_W-1:0]  a_raddr,
	output logic [IDX_W-1:0]   sum_raddr,
	output logic               sum_we,
	output logic [IDX_W-1:0]   sum_waddr,
	output imm_pkg::word_t     b_elem,
	output logic               clear_sum,
	input  imm_pkg::word_t     total,
	output logic               result_valid,
	output imm_pkg::word_t     product,
	output logic [IDX_W-1:0]   row_index,
	output logic [IDX_W-1:0]   col_index,
	output logic               column_done,
	output logic               matrix_done
);
	import imm_pkg::*;

	// Map a raw register value onto 1..MAX_DIM.
	function automatic logic [DIM_W-1:0] clamp_dim(input cfg_data_t v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	logic [DIM_W-1:0] rows_a_q, rows_b_q, inner_len_q;
	logic             loading_b_q;
	logic [IDX_W-1:0] row_count_q, inner_count_q;
	logic             restart;
	logic             accept;
	logic             row_end, last_a_row, last_b_row;

	imm_state_t       state_q, state_d;
	logic             issue;
	logic [IDX_W-1:0] m_q;
	logic             last_m;

	word_t            w_q;
	logic [IDX_W-1:0] job_k_q, job_col_q;
	logic             job_first_q, job_emit_q, job_last_col_q;

	logic             vld_s1, vld_s2;
	logic [IDX_W-1:0] m_s1, m_s2;
	logic             last_row_s2;

	assign accept  = start && !busy;
	assign restart = cfg_we && (cfg_index == REG_ROWS_A || cfg_index == REG_ROWS_B ||
		cfg_index == REG_INNER_LEN);

	assign row_end    = (DIM_W'(inner_count_q) + DIM_W'(1)) >= inner_len_q;
	assign last_a_row = (DIM_W'(row_count_q) + DIM_W'(1)) >= rows_a_q;
	assign last_b_row = (DIM_W'(row_count_q) + DIM_W'(1)) >= rows_b_q;
	assign last_m     = (DIM_W'(m_q) + DIM_W'(1)) == rows_a_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_W'(1);
			rows_b_q    <= DIM_W'(1);
			inner_len_q <= DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= clamp_dim(cfg_data);
				REG_ROWS_B:    rows_b_q    <= clamp_dim(cfg_data);
				REG_INNER_LEN: inner_len_q <= clamp_dim(cfg_data);
				default:       ;
			endcase
		end
	end

	// Stream position: which matrix, row and inner element comes next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loading_b_q   <= 1'b0;
			row_count_q   <= '0;
			inner_count_q <= '0;
		end else if (restart) begin
			loading_b_q   <= 1'b0;
			row_count_q   <= '0;
			inner_count_q <= '0;
		end else if (accept) begin
			if (!row_end) begin
				inner_count_q <= inner_count_q + IDX_W'(1);
			end else begin
				inner_count_q <= '0;
				if ((loading_b_q && last_b_row) || (!loading_b_q && last_a_row)) begin
					row_count_q <= '0;
					loading_b_q <= !loading_b_q;
				end else begin
					row_count_q <= row_count_q + IDX_W'(1);
				end
			end
		end
	end

	// Elements of A go straight into the A store.
	assign a_we    = accept && !loading_b_q;
	assign a_waddr = {row_count_q, inner_count_q};

	// Per-transaction context of a B element, held while its rows are swept.
	always_ff @(posedge clk) begin
		if (accept && loading_b_q) begin
			w_q            <= word;
			job_k_q        <= inner_count_q;
			job_col_q      <= row_count_q;
			job_first_q    <= (inner_count_q == '0);
			job_emit_q     <= row_end;
			job_last_col_q <= last_b_row;
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && loading_b_q) state_d = ST_RUN;
			ST_RUN:  if (last_m) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		issue = 1'b0;
		case (state_q)
			ST_IDLE: issue = 1'b0;
			ST_RUN:  issue = 1'b1;
			default: issue = 1'b0;
		endcase
		busy = (state_q != ST_IDLE) || vld_s1 || vld_s2;
	end

	// State, row sweep counter and stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_q     <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				m_q <= '0;
			end else if (issue) begin
				m_q <= m_q + IDX_W'(1);
			end
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	// Row tags follow the read and multiply stages.
	always_ff @(posedge clk) begin
		m_s1 <= m_q;
		m_s2 <= m_s1;
	end

	assign a_raddr   = {m_q, job_k_q};
	assign sum_raddr = m_q;
	assign b_elem    = w_q;
	assign clear_sum = job_first_q;

	// Partial sums go back to memory unless the column is complete.
	assign sum_we      = vld_s2 && !job_emit_q;
	assign sum_waddr   = m_s2;
	assign last_row_s2 = (DIM_W'(m_s2) + DIM_W'(1)) == rows_a_q;

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= vld_s2 && job_emit_q;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (vld_s2 && job_emit_q) begin
			product     <= total;
			row_index   <= m_s2;
			col_index   <= job_col_q;
			column_done <= last_row_s2;
			matrix_done <= last_row_s2 && job_last_col_q;
		end
	end

endmodule

>>> sv/integer_matrix_multiply.sv
// Integer matrix product C = A * transpose(B), one shared MAC unit.
// An A element is accepted while busy stays low. A B element keeps busy high
// while the MAC visits one row of A per cycle and its read and multiply
// stages drain. Results of a finished column pass the A-store read, MAC and
// result registers and leave one per cycle; the receiver cannot stall them.
// Asynchronous reset clears control state and sets all dimensions to 1.
module integer_matrix_multiply #(
	parameter int MAX_DIM = 32,
	localparam int IDX_W = $clog2(MAX_DIM)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  imm_pkg::cfg_idx_t  cfg_index,
	input  imm_pkg::cfg_data_t cfg_data,
	input  logic               start,
	input  imm_pkg::word_t     word,
	output logic               busy,
	output logic               result_valid,
	output imm_pkg::word_t     product,
	output logic [IDX_W-1:0]   row_index,
	output logic [IDX_W-1:0]   col_index,
	output logic               column_done,
	output logic               matrix_done
);
	import imm_pkg::*;
	`include "assert_macros.svh"

	localparam int AADR_W = 2 * IDX_W;

	logic              a_we;
	logic [AADR_W-1:0] a_waddr, a_raddr;
	logic [IDX_W-1:0]  sum_raddr, sum_waddr;
	logic              sum_we;
	logic              clear_sum;
	word_t             a_rdata, sum_rdata, b_elem, total;

	// Sequencer and stream control.
	imm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.word         (word),
		.busy         (busy),
		.a_we         (a_we),
		.a_waddr      (a_waddr),
		.a_raddr      (a_raddr),
		.sum_raddr    (sum_raddr),
		.sum_we       (sum_we),
		.sum_waddr    (sum_waddr),
		.b_elem       (b_elem),
		.clear_sum    (clear_sum),
		.total        (total),
		.result_valid (result_valid),
		.product      (product),
		.row_index    (row_index),
		.col_index    (col_index),
		.column_done  (column_done),
		.matrix_done  (matrix_done)
	);

	// Store of A, one row of 2**IDX_W slots per matrix row.
	imm_ram #(.WIDTH(WORD_W), .DEPTH(1 << AADR_W)) u_a_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (word),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	// Running sums of the column under construction, one per row of C.
	imm_ram #(.WIDTH(WORD_W), .DEPTH(1 << IDX_W)) u_col_sums (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (total),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	// Shared multiply-accumulate unit.
	imm_mac u_mac (
		.clk       (clk),
		.a_elem    (a_rdata),
		.b_elem    (b_elem),
		.sum_in    (sum_rdata),
		.clear_sum (clear_sum),
		.total     (total)
	);

	// A result only ever leaves right after the MAC pipeline was busy.
	`IMM_ASSERT_IMP(a_result_after_work, result_valid, $past(busy), "result without work")
	// The last element of C is always the last element of its column.
	`IMM_ASSERT_IMP(a_matrix_ends_column, result_valid && matrix_done, column_done,
		"matrix end inside a column")
	// The rows of one column leave in consecutive cycles.
	`IMM_ASSERT_NXT(a_column_unbroken, result_valid && !column_done, result_valid,
		"gap inside a column")

endmodule
